>>> sv/rbw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbw_pkg
// Shared types and constants of the IR beam window receiver: item layouts,
// configuration set, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package rbw_pkg;

    localparam int ADC_BITS      = 12;
    localparam int TIMER_BITS    = 16;
    localparam int SUM_BITS      = 28;
    localparam int TALLY_BITS    = 16;
    localparam int RUN_BITS      = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);

    localparam logic [ADC_BITS-1:0]   ADC_FULL_SCALE = {ADC_BITS{1'b1}};
    localparam logic [ADC_BITS-1:0]   ADC_MAX_VALID  = ADC_FULL_SCALE - ADC_BITS'(2);
    localparam logic [TALLY_BITS-1:0] TALLY_MAX      = {TALLY_BITS{1'b1}};

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_ON_THRESHOLD      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HYST_WIDTH        = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HYST_ENABLE       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL_TICKS    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_TICKS      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONFIRM_WINDOWS   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOST_WINDOWS      = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_IMMEDIATE   = 3'd7;

    typedef struct packed {
        logic                sync_edge;
        logic                sample_valid;
        logic [ADC_BITS-1:0] adc_sample;
    } tick_t;

    typedef struct packed {
        logic                  light_on;
        logic                  synced;
        logic                  window_open;
        logic                  window_done;
        logic [ADC_BITS-1:0]   window_average;
        logic [TALLY_BITS-1:0] counted_samples;
        logic                  window_ok;
        logic                  overrun;
    } result_t;

    typedef struct packed {
        logic [ADC_BITS-1:0]   on_threshold;
        logic [ADC_BITS-1:0]   hysteresis_width;
        logic                  hysteresis_enable;
        logic [TIMER_BITS-1:0] interval_ticks;
        logic [TIMER_BITS-1:0] window_ticks;
        logic [RUN_BITS-1:0]   confirm_windows;
        logic [RUN_BITS-1:0]   lost_windows;
        logic                  first_window_immediate;
    } cfg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic accumulate;
        logic div_start;
        logic div_step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage : rbw_pkg
`default_nettype wire

>>> sv/rbw_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbw_cfg
// Configuration register set, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module rbw_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [rbw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [rbw_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output rbw_pkg::cfg_t                            cfg
);
    import rbw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ON_THRESHOLD:    cfg_next.on_threshold      = cfg_data[ADC_BITS-1:0];
                CFG_HYST_WIDTH:      cfg_next.hysteresis_width  = cfg_data[ADC_BITS-1:0];
                CFG_HYST_ENABLE:     cfg_next.hysteresis_enable = cfg_data[0];
                CFG_INTERVAL_TICKS:  cfg_next.interval_ticks    = cfg_data[TIMER_BITS-1:0];
                CFG_WINDOW_TICKS:    cfg_next.window_ticks      = cfg_data[TIMER_BITS-1:0];
                CFG_CONFIRM_WINDOWS: cfg_next.confirm_windows   = cfg_data[RUN_BITS-1:0];
                CFG_LOST_WINDOWS:    cfg_next.lost_windows      = cfg_data[RUN_BITS-1:0];
                CFG_FIRST_IMMEDIATE: cfg_next.first_window_immediate = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_threshold           <= ADC_BITS'(200);
            cfg_reg.hysteresis_width       <= ADC_BITS'(120);
            cfg_reg.hysteresis_enable      <= 1'b1;
            cfg_reg.interval_ticks         <= TIMER_BITS'(1000);
            cfg_reg.window_ticks           <= TIMER_BITS'(40);
            cfg_reg.confirm_windows        <= RUN_BITS'(3);
            cfg_reg.lost_windows           <= RUN_BITS'(3);
            cfg_reg.first_window_immediate <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : rbw_cfg
`default_nettype wire

>>> sv/rbw_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbw_div
// Restoring divider for the window average, one quotient bit per step.
// ----------------------------------------------------------------------------
module rbw_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              step,
    input  wire logic [rbw_pkg::SUM_BITS-1:0]      dividend,
    input  wire logic [rbw_pkg::TALLY_BITS-1:0]    divisor,
    output logic      [rbw_pkg::SUM_BITS-1:0]      quotient,
    output logic                                   last
);
    import rbw_pkg::*;

    logic [SUM_BITS-1:0]     quot_reg, quot_next;
    logic [TALLY_BITS-1:0]   rem_reg, rem_next;
    logic [TALLY_BITS-1:0]   dvs_reg, dvs_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [TALLY_BITS:0]     shifted;
    logic [TALLY_BITS:0]     diff;
    logic                    ge;

    assign shifted = {rem_reg, quot_reg[SUM_BITS-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_BITS'(SUM_BITS - 1);
        end
        else if (step)
        begin
            // shift in one dividend bit, subtract where the divisor fits
            quot_next = {quot_reg[SUM_BITS-2:0], ge};
            rem_next  = ge ? diff[TALLY_BITS-1:0] : shifted[TALLY_BITS-1:0];
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign quotient = quot_reg;
    assign last     = cnt_reg == '0;

endmodule : rbw_div
`default_nettype wire

>>> sv/rbw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbw_ctrl
// Sequencer for one tick: load, accumulate, optional divide, commit.
// ----------------------------------------------------------------------------
module rbw_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  tick_valid,
    output logic                       tick_ready,
    input  rbw_pkg::dp_status_t        status,
    output rbw_pkg::dp_cmd_t           cmd
);
    import rbw_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        tick_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                tick_ready = 1'b1;
                if (tick_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.accumulate = 1'b1;
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule : rbw_ctrl
`default_nettype wire

>>> sv/rbw_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbw_dp
// Datapath: sync/interval/window state, sample accumulation, hysteresis
// verdict, run counters and the output register.
// ----------------------------------------------------------------------------
module rbw_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  rbw_pkg::cfg_t          cfg,
    input  rbw_pkg::tick_t         tick,
    input  rbw_pkg::dp_cmd_t       cmd,
    output rbw_pkg::dp_status_t    status,
    output rbw_pkg::result_t       result,
    output logic                   result_valid,
    input  wire logic              result_ready
);
    import rbw_pkg::*;

    tick_t                 tick_reg, tick_next;
    result_t               result_reg, result_next;
    logic                  result_valid_reg, result_valid_next;

    logic                  synced_reg, synced_next;
    logic [TIMER_BITS-1:0] ic_reg, ic_next;
    logic                  active_reg, active_next;
    logic [TIMER_BITS-1:0] wc_reg, wc_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [TALLY_BITS-1:0] tally_reg, tally_next;
    logic                  lvl_reg, lvl_next;
    logic [RUN_BITS-1:0]   good_reg, good_next;
    logic [RUN_BITS-1:0]   bad_reg, bad_next;
    logic                  light_reg, light_next;
    logic                  close_reg, close_next;

    logic                  acc_en;
    logic                  take;
    logic [SUM_BITS:0]     sum_wide;
    logic [SUM_BITS-1:0]   sum_acc;
    logic [TALLY_BITS-1:0] tally_acc;
    logic [TIMER_BITS-1:0] wc_inc;
    logic                  close_acc;
    logic [TALLY_BITS-1:0] tally_upd;

    logic [SUM_BITS-1:0]   quotient;
    logic                  div_last;
    logic [ADC_BITS-1:0]   avg_close;
    logic [ADC_BITS-1:0]   off_thr;

    rbw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (sum_next),
        .divisor  (tally_next),
        .quotient (quotient),
        .last     (div_last)
    );

    // accumulation step of the window
    assign acc_en    = synced_reg && active_reg;
    assign take      = tick_reg.sample_valid && (tick_reg.adc_sample < ADC_MAX_VALID);
    assign sum_wide  = {1'b0, sum_reg} + (SUM_BITS + 1)'(tick_reg.adc_sample);
    assign sum_acc   = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
    assign tally_acc = (tally_reg == TALLY_MAX) ? tally_reg : tally_reg + TALLY_BITS'(1);
    assign wc_inc    = wc_reg + TIMER_BITS'(1);
    assign close_acc = acc_en && (wc_inc >= cfg.window_ticks);
    assign tally_upd = take ? tally_acc : tally_reg;

    assign avg_close = (tally_reg == '0) ? ADC_FULL_SCALE : quotient[ADC_BITS-1:0];
    assign off_thr   = (cfg.on_threshold > cfg.hysteresis_width)
                     ? cfg.on_threshold - cfg.hysteresis_width : '0;

    always_comb
    begin
        logic ok;
        logic blocked;
        logic over;

        ok      = 1'b0;
        blocked = 1'b0;
        over    = 1'b0;

        tick_next         = cmd.load ? tick : tick_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        synced_next       = synced_reg;
        ic_next           = ic_reg;
        active_next       = active_reg;
        wc_next           = wc_reg;
        sum_next          = sum_reg;
        tally_next        = tally_reg;
        lvl_next          = lvl_reg;
        good_next         = good_reg;
        bad_next          = bad_reg;
        light_next        = light_reg;
        close_next        = close_reg;

        if (cmd.accumulate)
        begin
            close_next = close_acc;
            if (acc_en)
            begin
                wc_next = wc_inc;
                if (take)
                begin
                    sum_next   = sum_acc;
                    tally_next = tally_acc;
                end
            end
        end

        if (cmd.commit)
        begin
            if (!synced_reg)
            begin
                if (tick_reg.sync_edge)
                begin
                    synced_next = 1'b1;
                    ic_next     = '0;
                    active_next = cfg.first_window_immediate;
                    wc_next     = '0;
                    sum_next    = '0;
                    tally_next  = '0;
                    good_next   = '0;
                    bad_next    = '0;
                    lvl_next    = 1'b0;
                end
            end
            else
            begin
                if (close_reg)
                begin
                    active_next = 1'b0;
                    // on/off verdict, with hysteresis when enabled
                    if (!cfg.hysteresis_enable)
                    begin
                        ok = (avg_close < ADC_MAX_VALID) && (avg_close >= cfg.on_threshold);
                    end
                    else if (avg_close >= ADC_MAX_VALID)
                    begin
                        lvl_next = 1'b0;
                        ok       = 1'b0;
                    end
                    else
                    begin
                        if (!lvl_reg)
                        begin
                            lvl_next = avg_close >= cfg.on_threshold;
                        end
                        else
                        begin
                            lvl_next = !(avg_close <= off_thr);
                        end
                        ok = lvl_next;
                    end
                    // run counters
                    if (ok)
                    begin
                        bad_next  = '0;
                        good_next = (good_reg < cfg.confirm_windows)
                                  ? good_reg + RUN_BITS'(1) : good_reg;
                        if (good_next >= cfg.confirm_windows)
                        begin
                            light_next = 1'b1;
                        end
                    end
                    else
                    begin
                        good_next = '0;
                        bad_next  = (bad_reg < cfg.lost_windows)
                                  ? bad_reg + RUN_BITS'(1) : bad_reg;
                        if (bad_next >= cfg.lost_windows)
                        begin
                            // drop to blocked and unsynced
                            blocked     = 1'b1;
                            good_next   = '0;
                            bad_next    = '0;
                            synced_next = 1'b0;
                            ic_next     = '0;
                            active_next = 1'b0;
                            wc_next     = '0;
                            sum_next    = '0;
                            tally_next  = '0;
                            lvl_next    = 1'b0;
                            light_next  = 1'b0;
                        end
                    end
                end
                if (!blocked)
                begin
                    ic_next = ic_reg + TIMER_BITS'(1);
                    if (ic_next >= cfg.interval_ticks)
                    begin
                        ic_next = '0;
                        if (active_next)
                        begin
                            over = 1'b1;
                        end
                        else
                        begin
                            active_next = 1'b1;
                            wc_next     = '0;
                            sum_next    = '0;
                            tally_next  = '0;
                        end
                    end
                end
            end

            result_next.light_on        = light_next;
            result_next.synced          = synced_next;
            result_next.window_open     = active_next;
            result_next.window_done     = synced_reg && close_reg;
            result_next.window_average  = (synced_reg && close_reg) ? avg_close : '0;
            result_next.counted_samples = (synced_reg && close_reg) ? tally_reg : '0;
            result_next.window_ok       = ok;
            result_next.overrun         = over;
            result_valid_next           = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            synced_reg       <= 1'b0;
            ic_reg           <= '0;
            active_reg       <= 1'b0;
            wc_reg           <= '0;
            sum_reg          <= '0;
            tally_reg        <= '0;
            lvl_reg          <= 1'b0;
            good_reg         <= '0;
            bad_reg          <= '0;
            light_reg        <= 1'b0;
            close_reg        <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            synced_reg       <= synced_next;
            ic_reg           <= ic_next;
            active_reg       <= active_next;
            wc_reg           <= wc_next;
            sum_reg          <= sum_next;
            tally_reg        <= tally_next;
            lvl_reg          <= lvl_next;
            good_reg         <= good_next;
            bad_reg          <= bad_next;
            light_reg        <= light_next;
            close_reg        <= close_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg   <= tick_next;
        result_reg <= result_next;
    end

    assign status.need_div = close_acc && (tally_upd != '0);
    assign status.div_last = div_last;
    assign status.out_free = !result_valid_reg || result_ready;
    assign result          = result_reg;
    assign result_valid    = result_valid_reg;

endmodule : rbw_dp
`default_nettype wire

>>> sv/ir_beam_window_receiver.sv
`default_nettype none
// Timing: a tick's result is registered at commit, after the load and check states,
//   with the divide state in between when its window closes with counted samples
//   (serial divider, one quotient bit per cycle over the 28-bit sample sum).
// Flow: a new tick is taken only once the previous one is committed;
//   the next tick is taken while the previous result waits in the output register.
// Reset (rst_n, async, active low): unsynced, light off, all counters cleared,
//   configuration back to its defaults, no result pending.
// ----------------------------------------------------------------------------
// ir_beam_window_receiver
// Synchronous beam window detector with hysteresis: one tick item in, one
// result item out, windows timed from a sync edge.
// ----------------------------------------------------------------------------
module ir_beam_window_receiver (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // tick items
    input  wire logic                                tick_valid,
    output logic                                     tick_ready,
    input  rbw_pkg::tick_t                           tick,
    // result items
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output rbw_pkg::result_t                         result,
    // configuration writes
    input  wire logic                                cfg_we,
    input  wire logic [rbw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [rbw_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import rbw_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration registers; to be written only while no item is in flight (the block does not enforce this).
    rbw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: idle -> check (accumulate) -> divide when needed -> commit.
    // Commit waits for the output register, so a stalled consumer only holds
    // the tick after the one whose result is pending.
    rbw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: timers, window accumulator, divider, verdict and run counters.
    // The result register is loaded at commit; its valid flag drops when taken.
    rbw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .tick         (tick),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule : ir_beam_window_receiver
`default_nettype wire

>>> test/ir_beam_window_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_beam_window_receiver_tb
// Self-checking bench for the beam window receiver. Tick items go in over a
// valid/ready channel and every tick is mirrored in a behavioral copy of the
// window timing, averaging, hysteresis and run counters. Each result item that
// leaves the block is compared field by field with the oldest expected one.
// The run goes through a directed opening, then random phases with different
// register settings, idle patterns and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
import rbw_pkg::*;

class beam_window_scoreboard;

    // register copy
    logic [ADC_BITS-1:0]   cfg_on;
    logic [ADC_BITS-1:0]   cfg_hyst;
    logic                  cfg_hyst_en;
    logic [TIMER_BITS-1:0] cfg_interval;
    logic [TIMER_BITS-1:0] cfg_window;
    logic [RUN_BITS-1:0]   cfg_confirm;
    logic [RUN_BITS-1:0]   cfg_lost;
    logic                  cfg_first_imm;

    // receiver state
    logic                  synced;
    logic [TIMER_BITS-1:0] interval_cnt;
    logic                  win_active;
    logic [TIMER_BITS-1:0] win_cnt;
    logic [SUM_BITS-1:0]   adc_sum;
    logic [TALLY_BITS-1:0] adc_tally;
    logic                  level_high;
    logic [RUN_BITS-1:0]   good_run;
    logic [RUN_BITS-1:0]   bad_run;
    logic                  light;

    result_t expected_results[$];
    int      errors;

    function new();
        cfg_on        = 12'd200;
        cfg_hyst      = 12'd120;
        cfg_hyst_en   = 1'b1;
        cfg_interval  = 16'd1000;
        cfg_window    = 16'd40;
        cfg_confirm   = 4'd3;
        cfg_lost      = 4'd3;
        cfg_first_imm = 1'b0;
        errors        = 0;
        go_blocked();
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_ON_THRESHOLD:    cfg_on        = data[ADC_BITS-1:0];
            CFG_HYST_WIDTH:      cfg_hyst      = data[ADC_BITS-1:0];
            CFG_HYST_ENABLE:     cfg_hyst_en   = data[0];
            CFG_INTERVAL_TICKS:  cfg_interval  = data[TIMER_BITS-1:0];
            CFG_WINDOW_TICKS:    cfg_window    = data[TIMER_BITS-1:0];
            CFG_CONFIRM_WINDOWS: cfg_confirm   = data[RUN_BITS-1:0];
            CFG_LOST_WINDOWS:    cfg_lost      = data[RUN_BITS-1:0];
            CFG_FIRST_IMMEDIATE: cfg_first_imm = data[0];
            default:             ;
        endcase
    endfunction

    function void open_window();
        win_active = 1'b1;
        win_cnt    = '0;
        adc_sum    = '0;
        adc_tally  = '0;
    endfunction

    function void go_blocked();
        good_run     = '0;
        bad_run      = '0;
        synced       = 1'b0;
        interval_cnt = '0;
        win_active   = 1'b0;
        win_cnt      = '0;
        adc_sum      = '0;
        adc_tally    = '0;
        level_high   = 1'b0;
        light        = 1'b0;
    endfunction

    // On/off verdict of a closed window; updates the level state when enabled
    function logic judge_average(logic [SUM_BITS-1:0] avg);
        logic [ADC_BITS-1:0] off_level;
        if (!cfg_hyst_en)
            return (avg < ADC_MAX_VALID) && (avg >= cfg_on);
        if (avg >= ADC_MAX_VALID)
        begin
            level_high = 1'b0;
            return 1'b0;
        end
        off_level = (cfg_on > cfg_hyst) ? cfg_on - cfg_hyst : '0;
        if (!level_high)
        begin
            if (avg >= cfg_on)
                level_high = 1'b1;
        end
        else if (avg <= off_level)
            level_high = 1'b0;
        return level_high;
    endfunction

    // Advance the state by one accepted tick and queue the result it causes
    function void note_tick(tick_t t);
        result_t             r;
        logic [SUM_BITS:0]   acc;
        logic [SUM_BITS-1:0] avg;
        r = '0;
        if (!synced)
        begin
            if (t.sync_edge)
            begin
                synced       = 1'b1;
                interval_cnt = '0;
                win_active   = 1'b0;
                win_cnt      = '0;
                adc_sum      = '0;
                adc_tally    = '0;
                good_run     = '0;
                bad_run      = '0;
                level_high   = 1'b0;
                if (cfg_first_imm)
                    open_window();
            end
        end
        else
        begin
            if (win_active)
            begin
                if (t.sample_valid && t.adc_sample < ADC_MAX_VALID)
                begin
                    acc     = {1'b0, adc_sum} + (SUM_BITS + 1)'(t.adc_sample);
                    adc_sum = acc[SUM_BITS] ? {SUM_BITS{1'b1}} : acc[SUM_BITS-1:0];
                    if (adc_tally != TALLY_MAX)
                        adc_tally = adc_tally + 1'b1;
                end
                win_cnt = win_cnt + 1'b1;
                if (win_cnt >= cfg_window)
                begin
                    win_active        = 1'b0;
                    r.window_done     = 1'b1;
                    r.counted_samples = adc_tally;
                    avg = (adc_tally != 0) ? adc_sum / adc_tally : SUM_BITS'(ADC_FULL_SCALE);
                    r.window_average  = avg[ADC_BITS-1:0];
                    r.window_ok       = judge_average(avg);
                    if (r.window_ok)
                    begin
                        bad_run = '0;
                        if (good_run < cfg_confirm)
                            good_run = good_run + 1'b1;
                        if (!light && good_run >= cfg_confirm)
                            light = 1'b1;
                    end
                    else
                    begin
                        good_run = '0;
                        if (bad_run < cfg_lost)
                            bad_run = bad_run + 1'b1;
                        if (bad_run >= cfg_lost)
                            go_blocked();
                    end
                end
            end
            if (synced)
            begin
                interval_cnt = interval_cnt + 1'b1;
                if (interval_cnt >= cfg_interval)
                begin
                    interval_cnt = '0;
                    if (win_active)
                        r.overrun = 1'b1;
                    else
                        open_window();
                end
            end
        end
        r.light_on    = light;
        r.synced      = synced;
        r.window_open = win_active;
        expected_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result item arrived with no expectation waiting");
            errors++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("light_on", want.light_on, got.light_on);
        compare_field("synced", want.synced, got.synced);
        compare_field("window_open", want.window_open, got.window_open);
        compare_field("window_done", want.window_done, got.window_done);
        compare_field("window_average", want.window_average, got.window_average);
        compare_field("counted_samples", want.counted_samples, got.counted_samples);
        compare_field("window_ok", want.window_ok, got.window_ok);
        compare_field("overrun", want.overrun, got.overrun);
    endfunction

endclass

module ir_beam_window_receiver_tb;

    localparam int WATCHDOG_LIMIT = 5000;   // quiet cycles before giving up
    localparam int HOLD_CYCLES    = 400;    // long result back-pressure stretch
    localparam int TAIL_CYCLES    = 40;     // beyond the worst tick latency
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 150;

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     tick_valid   = 1'b0;
    logic                     tick_ready;
    tick_t                    tick_item    = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    result_t                  result_item;
    logic                     cfg_we       = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data     = '0;

    beam_window_scoreboard board;

    // idle control: the sender percentage belongs to the main process,
    // the stall percentage and hold-off counter to the result process
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_seq        = 0;
    int hold_seen       = 0;
    int hold_left       = 0;

    // beam profile of the random ticks: a target level held over a segment
    int seg_left    = 0;
    int beam_target = 0;

    ir_beam_window_receiver u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: check every accepted result, then pick the next ready.
    // A new hold request loads hold_left from HOLD_CYCLES and blanks ready until it runs out.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                board.check_result(result_item);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left    = hold_left - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((tick_valid && tick_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("Verification failed");
        $finish;
    end

    // Write one register; the predictor takes the value at the same edge
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // Write the whole register set back to back, then drop the enable
    task automatic load_config(input logic [11:0] on_thr, input logic [11:0] hyst,
                               input logic hyst_en, input logic [15:0] interval_len,
                               input logic [15:0] window_len, input logic [3:0] confirm,
                               input logic [3:0] lost, input logic first_imm);
        write_reg(CFG_ON_THRESHOLD, 16'(on_thr));
        write_reg(CFG_HYST_WIDTH, 16'(hyst));
        write_reg(CFG_HYST_ENABLE, 16'(hyst_en));
        write_reg(CFG_INTERVAL_TICKS, interval_len);
        write_reg(CFG_WINDOW_TICKS, window_len);
        write_reg(CFG_CONFIRM_WINDOWS, 16'(confirm));
        write_reg(CFG_LOST_WINDOWS, 16'(lost));
        write_reg(CFG_FIRST_IMMEDIATE, 16'(first_imm));
        cfg_we <= 1'b0;
    endtask

    // Offer one tick after a random gap and hold it until accepted.
    // With no gap, valid stays high and only the payload advances.
    task automatic send_tick(input tick_t t);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_item  <= t;
        do
            @(posedge clk);
        while (!tick_ready);
        board.note_tick(t);
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic drain_results();
        tick_valid <= 1'b0;
        while (board.expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic tick_t tick_of(input logic sync_edge, input logic sample_valid,
                                      input logic [11:0] adc);
        tick_t t;
        t.sync_edge    = sync_edge;
        t.sample_valid = sample_valid;
        t.adc_sample   = adc;
        return t;
    endfunction

    // Random tick: mostly a beam level held over a segment of ticks with a
    // little noise, sync edges offered often while unsynced, some raw noise
    function automatic tick_t make_tick();
        tick_t t;
        int    off_level;
        int    on_level;
        int    v;
        on_level  = int'(board.cfg_on);
        off_level = (board.cfg_on > board.cfg_hyst) ? on_level - int'(board.cfg_hyst) : 0;
        if (seg_left == 0)
        begin
            seg_left = int'($urandom_range(5, 80));
            case ($urandom_range(4))
                0:       beam_target = on_level + int'($urandom_range(0, 200));
                1:       beam_target = off_level - int'($urandom_range(0, 200));
                2:       beam_target = off_level + int'($urandom_range(0, on_level - off_level));
                3:       beam_target = -1;   // converter reports unusable codes
                default: beam_target = int'($urandom_range(0, 4095));
            endcase
        end
        seg_left = seg_left - 1;
        if ($urandom_range(9) == 0)
        begin
            t = tick_t'(14'($urandom));
            return t;
        end
        if (board.synced)
            t.sync_edge = ($urandom_range(19) == 0);
        else
            t.sync_edge = ($urandom_range(1) == 1);
        t.sample_valid = ($urandom_range(99) < 85);
        if (beam_target < 0)
            v = int'($urandom_range(int'(ADC_MAX_VALID), 4095));
        else
            v = beam_target + int'($urandom_range(0, 40)) - 20;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        t.adc_sample = 12'(v);
        return t;
    endfunction

    initial
    begin : main
        logic [11:0] on_thr;
        logic [11:0] hyst;
        logic [15:0] window_len;
        logic [15:0] interval_len;
        board = new();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part one: short windows, immediate first window, confirm
        // and lost runs of zero so one window decides light on or blocking
        load_config(12'd100, 12'd50, 1'b1, 16'd3, 16'd3, 4'd0, 4'd0, 1'b1);
        send_tick(tick_of(1'b0, 1'b1, 12'd4095));   // unsynced, no edge: nothing moves
        send_tick(tick_of(1'b1, 1'b0, 12'd0));      // sync edge opens a window at once
        send_tick(tick_of(1'b0, 1'b1, 12'd0));      // smallest sample
        send_tick(tick_of(1'b0, 1'b1, 12'd4092));   // largest counted sample
        send_tick(tick_of(1'b0, 1'b1, 12'd4092));   // window closes good: light on
        send_tick(tick_of(1'b1, 1'b1, 12'd4093));   // edge ignored while synced
        send_tick(tick_of(1'b0, 1'b0, 12'd50));     // sample not flagged valid
        send_tick(tick_of(1'b0, 1'b1, 12'd4094));   // empty window: invalid average, block
        send_tick(tick_of(1'b0, 1'b1, 12'd4095));   // back to unsynced
        drain_results();

        // Directed part two: zero interval and zero window, hysteresis off,
        // thresholds at the top so every window is bad
        load_config(12'd4095, 12'd4095, 1'b0, 16'd0, 16'd0, 4'd15, 4'd15, 1'b0);
        send_tick(tick_of(1'b1, 1'b0, 12'd0));
        send_tick(tick_of(1'b0, 1'b1, 12'd4092));
        send_tick(tick_of(1'b0, 1'b1, 12'd4092));
        send_tick(tick_of(1'b0, 1'b1, 12'd4095));
        send_tick(tick_of(1'b0, 1'b1, 12'd2048));
        send_tick(tick_of(1'b0, 1'b0, 12'd4095));
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // rotate through the idle patterns
            case (ph % 4)
                0:       begin sender_idle_pct = 0;  recv_stall_pct <= 0;  end
                1:       begin sender_idle_pct = 56; recv_stall_pct <= 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct <= 56; end
                default: begin sender_idle_pct = 18; recv_stall_pct <= 18; end
            endcase

            case (ph)
                2:  load_config(12'd0, 12'd0, 1'b1, 16'd1, 16'd1, 4'd1, 4'd1, 1'b1);
                5:  load_config(12'd1500, 12'd300, 1'b1, 16'd65535, 16'd6, 4'd2, 4'd2, 1'b1);
                7:  load_config(12'd1000, 12'd200, 1'b1, 16'd5, 16'd65535, 4'd3, 4'd3, 1'b1);
                9:  load_config(12'd800, 12'd100, 1'b1, 16'd0, 16'd0, 4'd0, 4'd0, 1'b0);
                10: load_config(12'd4095, 12'd4095, 1'b1, 16'd9, 16'd4, 4'd15, 4'd15, 1'b0);
                default:
                begin
                    on_thr     = 12'($urandom_range(300, 3500));
                    hyst       = 12'($urandom_range(0, 600));
                    window_len = 16'($urandom_range(1, 12));
                    // a few settings let the interval expire inside the window
                    if ($urandom_range(5) == 0)
                        interval_len = 16'($urandom_range(1, int'(window_len)));
                    else
                        interval_len = window_len + 16'($urandom_range(1, 12));
                    load_config(on_thr, hyst, ($urandom_range(9) < 7), interval_len,
                                window_len, 4'($urandom_range(1, 5)),
                                4'($urandom_range(1, 5)), 1'($urandom_range(1)));
                end
            endcase

            // back-pressure phase: stop taking results for a long stretch
            // while ticks keep coming, so the block fills and stalls its input
            if (ph == 4)
            begin
                sender_idle_pct = 0;
                hold_seq <= hold_seq + 1;
            end

            seg_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_tick(make_tick());
            drain_results();
        end

        // let any stray result show up, then judge the run
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.expected_results.size() != 0)
        begin
            $error("%0d expected result items never arrived", board.expected_results.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
